>>> src/prp_pkg.sv
// ============================================================================
// Permutation rank p-value package
// Shared constants, request and status codes and the item that travels down the chain.
// ============================================================================
package prp_pkg;

    localparam int MAX_PERMS   = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(MAX_PERMS);
    localparam int CNT_W       = $clog2(MAX_PERMS + 1);

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_QUERY = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_OVF  = 2'd2
    } status_t;

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_QUERY = 1'b1
    } item_kind_t;

    // The accumulator holds the running count of smaller values for a load
    // and the captured numerator for a query.
    typedef struct packed {
        logic                   valid;
        item_kind_t             kind;
        logic                   miss;
        logic                   ovf;
        logic [CNT_W-1:0]       n;
        logic [VALUE_WIDTH-1:0] value;
        logic [IDX_W-1:0]       idx;
        logic [IDX_W-1:0]       acc;
    } item_t;

endpackage

>>> src/permutation_rank_pvalue.sv
// ============================================================================
// Permutation rank p-value
// Keeps one set of permutation statistics in a chain of cells and answers
// rank queries with the empirical p-value numerator and denominator.
// ============================================================================
//
//  Channel  Direction  Contents
//  s_*      in         request: opcode in tuser, statistic and entry index
//  m_*      out        result of a query: numerator, set size, status
//
//  One request is taken per cycle while the result is not stalled; each request
//  walks the chain one cell per cycle under that condition, and a query result is
//  registered after the last cell; the length of the chain sets how long it takes.
//  Reset clears the set count, the overflow flag and all valid marks.
//  A stalled result holds the whole chain and drops s_tready.
//
module permutation_rank_pvalue
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // stat_value[31:0], entry_index[41:32], zero pad
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // p_numerator[9:0], set_size[20:10], status[22:21], pad
);

    logic [prp_pkg::CNT_W-1:0] loaded_count_reg;
    logic [prp_pkg::CNT_W-1:0] loaded_count_next;
    logic                      overflow_reg;
    logic                      overflow_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [prp_pkg::IDX_W-1:0] out_num_reg;
    logic [prp_pkg::CNT_W-1:0] out_size_reg;
    prp_pkg::status_t          out_status_reg;
    prp_pkg::status_t          tail_status;

    logic                      advance;
    logic                      accept;
    logic                      full;
    prp_pkg::opcode_t          op;
    prp_pkg::item_t            head_item;
    prp_pkg::item_t            tail_item;
    prp_pkg::item_t            chain [0:prp_pkg::MAX_PERMS];

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;
    assign op       = prp_pkg::opcode_t'(s_tuser);
    assign full     = loaded_count_reg == prp_pkg::CNT_W'(prp_pkg::MAX_PERMS);

    always_comb
    begin
        head_item.valid = 1'b0;
        head_item.kind  = prp_pkg::KIND_LOAD;
        head_item.miss  = {1'b0, s_tdata[41:32]} >= loaded_count_reg;
        head_item.ovf   = overflow_reg;
        head_item.n     = loaded_count_reg;
        head_item.value = s_tdata[prp_pkg::VALUE_WIDTH-1:0];
        head_item.idx   = s_tdata[41:32];
        head_item.acc   = '0;
        loaded_count_next = loaded_count_reg;
        overflow_next     = overflow_reg;
        case (op)
            prp_pkg::OP_CLEAR:
            begin
                if (accept)
                begin
                    loaded_count_next = '0;
                    overflow_next     = 1'b0;
                end
            end
            prp_pkg::OP_LOAD:
            begin
                head_item.valid = s_tvalid && !full;
                if (accept && full)
                begin
                    overflow_next = 1'b1;
                end
                else if (accept)
                begin
                    loaded_count_next = loaded_count_reg + prp_pkg::CNT_W'(1);
                end
            end
            prp_pkg::OP_QUERY:
            begin
                head_item.valid = s_tvalid;
                head_item.kind  = prp_pkg::KIND_QUERY;
            end
            default:
            begin
                head_item.valid = 1'b0;
            end
        endcase
    end

    assign chain[0] = head_item;

    genvar g;
    generate
        for (g = 0; g < prp_pkg::MAX_PERMS; g++)
        begin : g_cell
            prp_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .advance    (advance),
                .cell_index (prp_pkg::CNT_W'(g)),
                .item_in    (chain[g]),
                .item_out   (chain[g+1])
            );
        end
    endgenerate

    assign tail_item = chain[prp_pkg::MAX_PERMS];

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        if (advance)
        begin
            out_valid_next = tail_item.valid && (tail_item.kind == prp_pkg::KIND_QUERY);
        end
        if (tail_item.miss)
        begin
            tail_status = prp_pkg::ST_MISS;
        end
        else if (tail_item.ovf)
        begin
            tail_status = prp_pkg::ST_OVF;
        end
        else
        begin
            tail_status = prp_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_count_reg <= '0;
            overflow_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            loaded_count_reg <= loaded_count_next;
            overflow_reg     <= overflow_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_num_reg    <= tail_item.miss ? '0 : tail_item.acc;
            out_size_reg   <= tail_item.n;
            out_status_reg <= tail_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_status_reg, out_size_reg, out_num_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        loaded_count_reg <= prp_pkg::CNT_W'(prp_pkg::MAX_PERMS))
        else $error("Set count exceeds the store depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == prp_pkg::OP_CLEAR)) |=> (loaded_count_reg == '0) && !overflow_reg)
        else $error("Clear request did not empty the set.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_status_reg == prp_pkg::ST_MISS)) |-> (out_num_reg == '0))
        else $error("Miss result carries a nonzero numerator.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_status_reg != prp_pkg::ST_MISS))
            |-> ({1'b0, out_num_reg} < out_size_reg))
        else $error("Numerator is not below the set size.");

endmodule

>>> src/prp_cell.sv
// ============================================================================
// Permutation rank cell
// Holds one stored statistic and its count of smaller values, and hands the
// passing request on to the next cell.
// ============================================================================
module prp_cell
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic [prp_pkg::CNT_W-1:0] cell_index,
    input  prp_pkg::item_t           item_in,
    output prp_pkg::item_t           item_out
);

    logic [prp_pkg::VALUE_WIDTH-1:0] value_reg;
    logic [prp_pkg::VALUE_WIDTH-1:0] value_next;
    logic [prp_pkg::IDX_W-1:0]       count_reg;
    logic [prp_pkg::IDX_W-1:0]       count_next;
    prp_pkg::item_t                  item_reg;
    prp_pkg::item_t                  item_next;

    logic is_load;
    logic is_query;
    logic live;
    logic lt;
    logic gt;

    always_comb
    begin
        is_load   = item_in.valid && (item_in.kind == prp_pkg::KIND_LOAD);
        is_query  = item_in.valid && (item_in.kind == prp_pkg::KIND_QUERY);
        live      = cell_index < item_in.n;
        lt        = value_reg < item_in.value;
        gt        = value_reg > item_in.value;
        item_next = item_in;
        value_next = value_reg;
        count_next = count_reg;
        if (is_load && live && lt)
        begin
            item_next.acc = item_in.acc + prp_pkg::IDX_W'(1);
        end
        if (is_load && live && gt)
        begin
            count_next = count_reg + prp_pkg::IDX_W'(1);
        end
        if (is_load && (item_in.n == cell_index))
        begin
            value_next = item_in.value;
            count_next = item_in.acc;
        end
        if (is_query && !item_in.miss && ({1'b0, item_in.idx} == cell_index))
        begin
            item_next.acc = prp_pkg::IDX_W'(item_in.n - prp_pkg::CNT_W'(1)
                                           - {1'b0, count_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else if (advance)
        begin
            item_reg <= item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            value_reg <= value_next;
            count_reg <= count_next;
        end
    end

    assign item_out = item_reg;

endmodule
